@@ hdl/pdc_pkg.sv @@
// Shared constants and types for the deadband PID controller.
package pdc_pkg;

    // Default data format: Q16.16 in 32-bit two's complement.
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register index.
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_PROP_GAIN   = 3'd0;
    localparam t_cfg_idx CFG_INTEG_GAIN  = 3'd1;
    localparam t_cfg_idx CFG_DERIV_GAIN  = 3'd2;
    localparam t_cfg_idx CFG_INTEG_LIMIT = 3'd3;
    localparam t_cfg_idx CFG_OUT_LIMIT   = 3'd4;
    localparam t_cfg_idx CFG_DEAD_ZONE   = 3'd5;

endpackage

@@ hdl/pdc_terms.sv @@
// Gain multiply, term sum and output clamp pipeline of the deadband PID controller.
module pdc_terms #(
    parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pdc_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // upstream side
    input  logic                         i_vld,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_e,
    input  logic signed [DATA_WIDTH-1:0] i_sum,
    input  logic signed [DATA_WIDTH:0]   i_diff,
    // configuration
    input  logic signed [DATA_WIDTH-1:0] i_prop_gain,
    input  logic signed [DATA_WIDTH-1:0] i_integ_gain,
    input  logic signed [DATA_WIDTH-1:0] i_deriv_gain,
    input  logic        [DATA_WIDTH-2:0] i_out_limit,
    // downstream side
    output logic                         o_vld,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_drive
);
    import pdc_pkg::*;

    localparam int PROD_W = 2 * DATA_WIDTH + 1;
    localparam int ACC_W  = 2 * DATA_WIDTH + 3;

    logic r_vld_b, r_vld_c, r_vld_d;
    logic en_b, en_c, en_d;

    logic signed [2*DATA_WIDTH-1:0] r_prod_p, r_prod_i;
    logic signed [PROD_W-1:0]       r_prod_d;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [DATA_WIDTH-1:0]   r_drive;

    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] n_term_p, n_term_i, n_term_d;
    logic signed [ACC_W-1:0] n_lim, n_nlim, n_clamped;

    // a stage loads when empty or when its content moves on
    assign en_d    = !r_vld_d || !i_stall;
    assign en_c    = !r_vld_c || en_d;
    assign en_b    = !r_vld_b || en_c;
    assign o_stall = !en_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (en_b) begin
                r_vld_b <= i_vld;
            end
            if (en_c) begin
                r_vld_c <= r_vld_b;
            end
            if (en_d) begin
                r_vld_d <= r_vld_c;
            end
        end
    end

    // stage B: the three exact products
    always_ff @(posedge i_clk) begin
        if (en_b && i_vld) begin
            r_prod_p <= (2*DATA_WIDTH)'(i_e) * (2*DATA_WIDTH)'(i_prop_gain);
            r_prod_i <= (2*DATA_WIDTH)'(i_sum) * (2*DATA_WIDTH)'(i_integ_gain);
            r_prod_d <= PROD_W'(i_diff) * PROD_W'(i_deriv_gain);
        end
    end

    // stage C: drop fraction bits (floor) and add exactly
    assign n_term_p = ACC_W'(r_prod_p >>> FRAC_BITS);
    assign n_term_i = ACC_W'(r_prod_i >>> FRAC_BITS);
    assign n_term_d = ACC_W'(r_prod_d >>> FRAC_BITS);
    assign n_acc    = n_term_p + n_term_i + n_term_d;

    always_ff @(posedge i_clk) begin
        if (en_c && r_vld_b) begin
            r_acc <= n_acc;
        end
    end

    // stage D: saturate to the symmetric output limit
    assign n_lim  = ACC_W'({1'b0, i_out_limit});
    assign n_nlim = -n_lim;

    always_comb begin
        if (r_acc > n_lim) begin
            n_clamped = n_lim;
        end else if (r_acc < n_nlim) begin
            n_clamped = n_nlim;
        end else begin
            n_clamped = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d && r_vld_c) begin
            r_drive <= n_clamped[DATA_WIDTH-1:0];
        end
    end

    assign o_vld   = r_vld_d;
    assign o_drive = r_drive;

    // backpressure upstream only when every stage is full and the sink stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld_b && r_vld_c && r_vld_d && i_stall))
        else $error("pdc_terms: stall without a full pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !(r_vld_b || r_vld_c || r_vld_d))
        else $error("pdc_terms: pipeline not empty after reset");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_c && en_d) |=> r_vld_d)
        else $error("pdc_terms: item lost between sum and output stage");

endmodule

@@ hdl/pid_deadband_clamped.sv @@
// Top level of the positional PID controller with input dead zone and integral clamp.
//
// Positional PID controller in signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction
// bits, Q16.16 by default). Each transfer on the input channel carries one error sample;
// an error whose magnitude is below dead_zone is taken as zero. The integral is
// clamped to +/-integ_limit, the derivative is this error minus the previous one,
// each gain product is floored by FRAC_BITS and the exact sum is saturated to
// +/-out_limit. Every input transfer yields exactly one drive transfer, in order.
// Throughput is one item per clock while the output is not stalled; output valid rises
// once the input transfer has passed through four register stages (state stage,
// multiply stage, sum stage, clamp/output register).
// The recurrence through the dead zone compare, integral add and clamp
// sets the clock limit of the state stage. Config registers are written through
// i_cfg_we/i_cfg_index/i_cfg_data; write them only while the pipeline is empty.
// Synchronous reset sets gains 0, limits full scale,
// dead_zone floor(0.03 * 2^FRAC_BITS).
module pid_deadband_clamped #(
    parameter int DATA_WIDTH = pdc_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pdc_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  pdc_pkg::t_cfg_idx            i_cfg_index,
    input  logic        [DATA_WIDTH-1:0] i_cfg_data,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_error_sample,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_drive
);
    import pdc_pkg::*;

    localparam int LIM_W = DATA_WIDTH - 1;
    // dead zone reset value: floor(0.03 in fixed point)
    localparam logic [63:0] DZ_FULL = (64'd3 << FRAC_BITS) / 64'd100;
    localparam logic [LIM_W-1:0] DZ_RESET = DZ_FULL[LIM_W-1:0];

    // configuration registers
    logic signed [DATA_WIDTH-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic        [LIM_W-1:0]      r_integ_limit, r_out_limit, r_dead_zone;

    // controller state
    logic signed [DATA_WIDTH-1:0] r_prev_error, r_error_sum;

    // state stage output register
    logic                         r_vld_a;
    logic signed [DATA_WIDTH-1:0] r_e, r_sum;
    logic signed [DATA_WIDTH:0]   r_diff;

    logic en_a, in_xfer, t_stall;

    logic        [DATA_WIDTH-1:0] n_mag;
    logic signed [DATA_WIDTH-1:0] n_e, n_sum;
    logic signed [DATA_WIDTH:0]   n_raw_sum, n_ilim, n_nlim, n_clamped, n_diff;

    // ---------------------------------------------------------------
    // Configuration writes; unknown indexes are dropped.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_integ_limit <= '1;
            r_out_limit   <= '1;
            r_dead_zone   <= DZ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data;
                CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIM_W-1:0];
                CFG_OUT_LIMIT:   r_out_limit   <= i_cfg_data[LIM_W-1:0];
                CFG_DEAD_ZONE:   r_dead_zone   <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the state stage loads when empty or when its item
    // moves into the multiply pipeline.
    // ---------------------------------------------------------------
    assign en_a       = !r_vld_a || !t_stall;
    assign o_in_stall = !en_a;
    assign in_xfer    = i_in_valid && en_a;

    // ---------------------------------------------------------------
    // State stage: dead zone, clamped integral, difference.
    // The most negative sample has magnitude 2^(DATA_WIDTH-1), which
    // the unsigned DATA_WIDTH-bit negate yields correctly.
    // ---------------------------------------------------------------
    assign n_mag = i_error_sample[DATA_WIDTH-1] ? DATA_WIDTH'(~i_error_sample + 1'b1)
                                                 : i_error_sample;
    assign n_e   = (n_mag < {1'b0, r_dead_zone}) ? '0 : i_error_sample;

    assign n_raw_sum = {n_e[DATA_WIDTH-1], n_e} + {r_error_sum[DATA_WIDTH-1], r_error_sum};
    assign n_ilim    = {2'b00, r_integ_limit};
    assign n_nlim    = -n_ilim;

    always_comb begin
        if (n_raw_sum > n_ilim) begin
            n_clamped = n_ilim;
        end else if (n_raw_sum < n_nlim) begin
            n_clamped = n_nlim;
        end else begin
            n_clamped = n_raw_sum;
        end
    end

    // clamped integral always fits the data width
    assign n_sum  = n_clamped[DATA_WIDTH-1:0];
    assign n_diff = {n_e[DATA_WIDTH-1], n_e} - {r_prev_error[DATA_WIDTH-1], r_prev_error};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a      <= 1'b0;
            r_prev_error <= '0;
            r_error_sum  <= '0;
        end else begin
            if (en_a) begin
                r_vld_a <= i_in_valid;
            end
            // advance controller state on every accepted sample
            if (in_xfer) begin
                r_prev_error <= n_e;
                r_error_sum  <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_e    <= n_e;
            r_sum  <= n_sum;
            r_diff <= n_diff;
        end
    end

    // ---------------------------------------------------------------
    // Multiply, sum and saturate pipeline with the output register.
    // ---------------------------------------------------------------
    pdc_terms #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_terms (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_vld_a),
        .o_stall      (t_stall),
        .i_e          (r_e),
        .i_sum        (r_sum),
        .i_diff       (r_diff),
        .i_prop_gain  (r_prop_gain),
        .i_integ_gain (r_integ_gain),
        .i_deriv_gain (r_deriv_gain),
        .i_out_limit  (r_out_limit),
        .o_vld        (o_out_valid),
        .i_stall      (i_out_stall),
        .o_drive      (o_drive)
    );

    // input stalls only while the state stage holds an item that cannot move
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_vld_a && t_stall))
        else $error("pid_deadband_clamped: input stalled with room in state stage");

    // previous error tracks the item handed to the pipeline
    a_prev_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_prev_error == r_e))
        else $error("pid_deadband_clamped: previous error out of step");

    // difference uses the previous error from before this transfer
    a_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_diff == ((DATA_WIDTH+1)'(r_e) - (DATA_WIDTH+1)'($past(r_prev_error)))))
        else $error("pid_deadband_clamped: derivative difference wrong");

endmodule
